[src/mcg_pkg.sv]
// Shared widths, register indexes, stage payload types and helpers for the color gradient
package mcg_pkg;

    localparam int STEP_W     = 8;
    localparam int CHAN_W     = 8;
    localparam int NCHAN      = 3;
    localparam int COLOR_W    = NCHAN * CHAN_W;
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int CNT_W      = 3;
    localparam int SEG_W      = 3;
    localparam int SCALED_W   = STEP_W + SEG_W;
    localparam int NUM_W      = 2 * CHAN_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COLOR_0 = CFG_IDX_W'(1);

    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [COLOR_W-1:0] t_color;

    // Segment stage result: stop index, blend remainder and divisor
    typedef struct packed {
        logic             off;
        logic [SEG_W-1:0] seg;
        t_chan            rem;
        t_chan            div;
    } t_seg_res;

    // Per-channel numerators waiting for the divide by the step total
    typedef struct packed {
        logic [NCHAN-1:0][NUM_W-1:0] num;
        t_chan                       div;
    } t_div_req;

    typedef logic [NCHAN-1:0][CHAN_W-1:0] t_quo;

    // Channel k of a packed color: 0 red, 1 green, 2 blue
    function automatic t_chan chan_of(input t_color color, input int k);
        return color[COLOR_W-1-k*CHAN_W -: CHAN_W];
    endfunction

endpackage

[src/mcg_step_if.sv]
// Step request channel: current step and total steps
interface mcg_step_if;
    import mcg_pkg::*;

    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] step_now;
    logic [STEP_W-1:0] step_total;

    modport source (output valid, output step_now, output step_total, input ready);
    modport sink   (input valid, input step_now, input step_total, output ready);
endinterface

[src/mcg_pix_if.sv]
// Pixel result channel: blended channels and the packed serial word
interface mcg_pix_if;
    import mcg_pkg::*;

    logic             valid;
    logic             ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [PIX_W-1:0]  pixel_word;

    modport source (output valid, output red, output green, output blue, output pixel_word,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input pixel_word,
                    output ready);
endinterface

[src/mcg_cfg_if.sv]
// Configuration write channel: register index and write data
interface mcg_cfg_if;
    import mcg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/mcg_seg.sv]
// Two pipeline stages: clamp and scale the step, then divide out the segment index
module mcg_seg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mcg_pkg::STEP_W-1:0] i_step_now,
    input  logic [mcg_pkg::STEP_W-1:0] i_step_total,
    input  logic [mcg_pkg::CNT_W:0]    i_stop_n,
    output logic                       o_valid,
    input  logic                       i_ready,
    output mcg_pkg::t_seg_res          o_res
);
    import mcg_pkg::*;

    logic                en_a;
    logic                en_b;
    logic                a_off;
    logic                a_first;
    logic [STEP_W-1:0]   a_clamp;
    logic [SEG_W-1:0]    a_segs;
    logic [SEG_W-1:0]    a_last;
    logic [SCALED_W-1:0] a_scaled;
    t_chan               a_div;
    t_seg_res            b_res;

    logic                r_a_v;
    logic                r_a_off;
    logic [SEG_W-1:0]    r_a_last;
    logic [SCALED_W-1:0] r_a_scaled;
    t_chan               r_a_div;
    logic                r_b_v;
    t_seg_res            r_b_res;

    // Advance a stage when it is empty or the next one advances
    assign en_b    = !r_b_v || i_ready;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;

    // Stage A: classify, clamp the step and scale it by the segment count
    always_comb begin
        a_off    = (i_stop_n == '0);
        a_first  = (i_stop_n == (CNT_W+1)'(1)) || (i_step_total == '0);
        a_clamp  = (i_step_now < i_step_total) ? i_step_now : i_step_total;
        a_segs   = (a_off || a_first) ? '0 : SEG_W'(i_stop_n - (CNT_W+1)'(1));
        a_last   = (a_off || a_first) ? '0 : SEG_W'(i_stop_n - (CNT_W+1)'(2));
        a_scaled = SCALED_W'(a_clamp) * SCALED_W'(a_segs);
        a_div    = (a_off || a_first) ? CHAN_W'(1) : i_step_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en_a) begin
            r_a_v <= i_valid;
        end
        if (en_a && i_valid) begin
            r_a_off    <= a_off;
            r_a_last   <= a_last;
            r_a_scaled <= a_scaled;
            r_a_div    <= a_div;
        end
    end

    // Stage B: restoring divide for the segment index, then cap at the last segment
    always_comb begin : b_calc
        logic [SCALED_W-1:0] rem;
        logic [SCALED_W-1:0] trial;
        logic [SEG_W-1:0]    q;
        rem = r_a_scaled;
        q   = '0;
        for (int i = SEG_W - 1; i >= 0; i--) begin
            trial = SCALED_W'(r_a_div) << i;
            if (rem >= trial) begin
                rem  = rem - trial;
                q[i] = 1'b1;
            end
        end
        b_res.off = r_a_off;
        b_res.div = r_a_div;
        if (q > r_a_last) begin
            b_res.seg = r_a_last;
            b_res.rem = r_a_div;
        end else begin
            b_res.seg = q;
            b_res.rem = rem[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en_b) begin
            r_b_v <= r_a_v;
        end
        if (en_b && r_a_v) begin
            r_b_res <= b_res;
        end
    end

    assign o_valid = r_b_v;
    assign o_res   = r_b_res;

endmodule

[src/mcg_mix.sv]
// Color stop store with registered two-port read, and the per-channel blend products
module mcg_mix #(
    parameter int MAX_STOPS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_STOPS)-1:0]  i_wr_slot,
    input  logic [mcg_pkg::COLOR_W-1:0]   i_wr_color,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  mcg_pkg::t_seg_res             i_res,
    output logic                          o_valid,
    input  logic                          i_ready,
    output mcg_pkg::t_div_req             o_req
);
    import mcg_pkg::*;

    localparam int IDX_W = $clog2(MAX_STOPS);

    logic                en_c;
    logic                en_d;
    logic [SEG_W-1:0]    seg_e;
    logic [IDX_W-1:0]    idx_s;
    logic [IDX_W-1:0]    idx_e;
    t_div_req            d_req;

    t_color              r_color [MAX_STOPS];
    logic [MAX_STOPS-1:0] r_color_vld;
    logic                r_c_v;
    t_color              r_c_s;
    t_color              r_c_e;
    t_chan               r_c_rem;
    t_chan               r_c_div;
    logic                r_d_v;
    t_div_req            r_d_req;

    assign en_d    = !r_d_v || i_ready;
    assign en_c    = !r_c_v || en_d;
    assign o_ready = en_c;

    assign seg_e = i_res.seg + SEG_W'(1);
    assign idx_s = i_res.seg[IDX_W-1:0];
    assign idx_e = seg_e[IDX_W-1:0];

    // Write a stop; an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_vld <= '0;
        end else if (i_wr_en) begin
            r_color_vld[i_wr_slot] <= 1'b1;
        end
        if (i_wr_en) begin
            r_color[i_wr_slot] <= i_wr_color;
        end
    end

    // Stage C: read the start and end stops of the segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en_c) begin
            r_c_v <= i_valid;
        end
        if (en_c && i_valid) begin
            r_c_s   <= (i_res.off || !r_color_vld[idx_s]) ? '0 : r_color[idx_s];
            r_c_e   <= (i_res.off || !r_color_vld[idx_e]) ? '0 : r_color[idx_e];
            r_c_rem <= i_res.rem;
            r_c_div <= i_res.div;
        end
    end

    // Stage D: weight both stops per channel and sum
    always_comb begin : d_calc
        t_chan inv;
        inv = r_c_div - r_c_rem;
        for (int k = 0; k < NCHAN; k++) begin
            d_req.num[k] = NUM_W'(chan_of(r_c_s, k)) * NUM_W'(inv)
                         + NUM_W'(chan_of(r_c_e, k)) * NUM_W'(r_c_rem);
        end
        d_req.div = r_c_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en_d) begin
            r_d_v <= r_c_v;
        end
        if (en_d && r_c_v) begin
            r_d_req <= d_req;
        end
    end

    assign o_valid = r_d_v;
    assign o_req   = r_d_req;

endmodule

[src/mcg_div.sv]
// Pipelined restoring divider, three channel lanes, half the quotient bits per stage
module mcg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mcg_pkg::t_div_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output mcg_pkg::t_quo     o_quo
);
    import mcg_pkg::*;

    localparam int STEP_BITS = CHAN_W / 2;

    logic                        en_e;
    logic                        en_f;
    logic [NCHAN-1:0][NUM_W-1:0] e_rem;
    t_quo                        e_q;
    t_quo                        f_q;

    logic                        r_e_v;
    logic [NCHAN-1:0][NUM_W-1:0] r_e_rem;
    t_quo                        r_e_q;
    t_chan                       r_e_div;
    logic                        r_f_v;
    t_quo                        r_f_q;

    assign en_f    = !r_f_v || i_ready;
    assign en_e    = !r_e_v || en_f;
    assign o_ready = en_e;

    // Stage E: upper quotient bits
    always_comb begin : e_calc
        logic [NUM_W-1:0]  rem;
        logic [NUM_W-1:0]  trial;
        logic [CHAN_W-1:0] q;
        for (int k = 0; k < NCHAN; k++) begin
            rem = i_req.num[k];
            q   = '0;
            for (int i = CHAN_W - 1; i >= STEP_BITS; i--) begin
                trial = NUM_W'(i_req.div) << i;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    q[i] = 1'b1;
                end
            end
            e_rem[k] = rem;
            e_q[k]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en_e) begin
            r_e_v <= i_valid;
        end
        if (en_e && i_valid) begin
            r_e_rem <= e_rem;
            r_e_q   <= e_q;
            r_e_div <= i_req.div;
        end
    end

    // Stage F: lower quotient bits
    always_comb begin : f_calc
        logic [NUM_W-1:0]  rem;
        logic [NUM_W-1:0]  trial;
        logic [CHAN_W-1:0] q;
        for (int k = 0; k < NCHAN; k++) begin
            rem = r_e_rem[k];
            q   = r_e_q[k];
            for (int i = STEP_BITS - 1; i >= 0; i--) begin
                trial = NUM_W'(r_e_div) << i;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    q[i] = 1'b1;
                end
            end
            f_q[k] = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en_f) begin
            r_f_v <= r_e_v;
        end
        if (en_f && r_e_v) begin
            r_f_q <= f_q;
        end
    end

    assign o_valid = r_f_v;
    assign o_quo   = r_f_q;

endmodule

[src/multi_stop_color_gradient_top.sv]
// Multi-stop linear color gradient: top level with configuration and output register
//
// Usage:
//   i_cfg   writes registers: index 0 is the stop count, index 1+k holds stop k
//           (red 23:16, green 15:8, blue 7:0). Indexes past the last stop are
//           dropped. The port is always ready; write only while the block is idle.
//   i_step  takes a request with step_now and step_total, one per cycle while ready is high.
//   o_pix   returns red, green, blue and the packed G,R,B word (low byte zero),
//           one result per request, in request order.
// Timing:
//   From acceptance to o_pix.valid a request passes the clamp/scale, segment
//   divide, stop read, blend products, two divide stages and output registers.
//   Throughput is one request per cycle while o_pix.ready stays high; the
//   divide by step_total takes two of the pipeline stages.
// Reset:
//   The stop count clears to zero (output off) and every stop reads as zero
//   until written. The pipeline empties.
// Stall:
//   When o_pix.ready is low the result holds; earlier stages keep filling until
//   all are full, and only then does i_step.ready drop. Nothing is lost or repeated.
module multi_stop_color_gradient_top #(
    parameter int MAX_STOPS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcg_step_if.sink    i_step,
    mcg_cfg_if.sink     i_cfg,
    mcg_pix_if.source   o_pix
);
    import mcg_pkg::*;

    localparam int               IDX_W    = $clog2(MAX_STOPS);
    localparam logic [CNT_W:0]   STOP_MAX = (CNT_W+1)'(MAX_STOPS);

    logic                 cfg_wr_color;
    logic [CFG_IDX_W-1:0] cfg_off;
    logic [CNT_W:0]       stop_n;
    logic                 seg_valid;
    logic                 seg_ready;
    t_seg_res             seg_res;
    logic                 mix_valid;
    logic                 mix_ready;
    t_div_req             mix_req;
    logic                 div_valid;
    t_quo                 div_quo;
    logic                 en_o;

    logic [CNT_W-1:0]     r_stop_count;
    logic                 r_o_v;
    t_chan                r_o_red;
    t_chan                r_o_green;
    t_chan                r_o_blue;

    // Configuration: stop count here, stop colors in the store
    assign i_cfg.ready  = 1'b1;
    assign cfg_off      = i_cfg.index - REG_STOP_COLOR_0;
    assign cfg_wr_color = i_cfg.valid && (i_cfg.index >= REG_STOP_COLOR_0)
                          && (i_cfg.index <= CFG_IDX_W'(MAX_STOPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= '0;
        end else if (i_cfg.valid && i_cfg.index == REG_STOP_COUNT) begin
            r_stop_count <= i_cfg.data[CNT_W-1:0];
        end
    end

    // Saturate the stop count to the store depth
    assign stop_n = ({1'b0, r_stop_count} > STOP_MAX) ? STOP_MAX : {1'b0, r_stop_count};

    mcg_seg u_seg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_step.valid),
        .o_ready      (i_step.ready),
        .i_step_now   (i_step.step_now),
        .i_step_total (i_step.step_total),
        .i_stop_n     (stop_n),
        .o_valid      (seg_valid),
        .i_ready      (seg_ready),
        .o_res        (seg_res)
    );

    mcg_mix #(
        .MAX_STOPS (MAX_STOPS)
    ) u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (cfg_wr_color),
        .i_wr_slot  (cfg_off[IDX_W-1:0]),
        .i_wr_color (i_cfg.data[COLOR_W-1:0]),
        .i_valid    (seg_valid),
        .o_ready    (seg_ready),
        .i_res      (seg_res),
        .o_valid    (mix_valid),
        .i_ready    (mix_ready),
        .o_req      (mix_req)
    );

    mcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .o_ready (mix_ready),
        .i_req   (mix_req),
        .o_valid (div_valid),
        .i_ready (en_o),
        .o_quo   (div_quo)
    );

    // Output register: hold the result until the receiver takes it
    assign en_o = !r_o_v || o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en_o) begin
            r_o_v <= div_valid;
        end
        if (en_o && div_valid) begin
            r_o_red   <= div_quo[0];
            r_o_green <= div_quo[1];
            r_o_blue  <= div_quo[2];
        end
    end

    assign o_pix.valid      = r_o_v;
    assign o_pix.red        = r_o_red;
    assign o_pix.green      = r_o_green;
    assign o_pix.blue       = r_o_blue;
    assign o_pix.pixel_word = {r_o_green, r_o_red, r_o_blue, CHAN_W'(0)};

endmodule

[test/multi_stop_color_gradient_top_test.sv]
// Self-checking test of the multi-stop color gradient: directed and random steps
`timescale 1ns / 100ps

module multi_stop_color_gradient_top_test;
    import mcg_pkg::*;

    localparam int STOPS          = 4;
    localparam int LATENCY        = 7;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [STEP_W-1:0] now;
        logic [STEP_W-1:0] total;
    } t_step_req;

    typedef struct packed {
        t_chan            red;
        t_chan            green;
        t_chan            blue;
        logic [PIX_W-1:0] word;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mcg_step_if step_if ();
    mcg_cfg_if  cfg_if ();
    mcg_pix_if  pix_if ();

    multi_stop_color_gradient_top #(
        .MAX_STOPS (STOPS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step_if),
        .i_cfg   (cfg_if),
        .o_pix   (pix_if)
    );

    // Mirror of the configuration registers
    logic [CNT_W-1:0] stop_cnt = '0;
    t_color           stop_tbl [STOPS] = '{default: '0};

    t_step_req pending_steps [$];
    t_pixel    predicted_pixels [$];
    int        errors       = 0;
    bit        quiet_run    = 1'b0;
    int        step_gap     = 0;
    int        pix_hold     = 0;
    int        stall_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Color of the gradient at one step, from the mirrored stops
    function automatic t_pixel blend_pixel(input logic [STEP_W-1:0] now,
                                           input logic [STEP_W-1:0] total);
        logic [CNT_W-1:0]    n;
        logic [SEG_W-1:0]    segs;
        logic [SCALED_W-1:0] scaled;
        logic [SCALED_W-1:0] seg;
        logic [SCALED_W-1:0] rem;
        logic [NUM_W-1:0]    num;
        t_color              s;
        t_color              e;
        t_chan               q [NCHAN];
        t_pixel              px;
        n = (stop_cnt > STOPS) ? CNT_W'(STOPS) : stop_cnt;
        s = stop_tbl[0];
        for (int k = 0; k < NCHAN; k++) q[k] = '0;
        if (n == 1 || (n > 1 && total == 0)) begin
            // single stop or no transition: first stop as is
            for (int k = 0; k < NCHAN; k++) q[k] = s[COLOR_W-1-k*CHAN_W -: CHAN_W];
        end else if (n > 1) begin
            segs   = SEG_W'(n - 1);
            scaled = SCALED_W'(now < total ? now : total) * SCALED_W'(segs);
            seg    = scaled / SCALED_W'(total);
            if (seg > SCALED_W'(segs) - SCALED_W'(1)) seg = SCALED_W'(segs) - SCALED_W'(1);
            rem = scaled - seg * SCALED_W'(total);
            s   = stop_tbl[seg];
            e   = stop_tbl[seg + 1];
            for (int k = 0; k < NCHAN; k++) begin
                num  = NUM_W'(s[COLOR_W-1-k*CHAN_W -: CHAN_W]) * NUM_W'(SCALED_W'(total) - rem)
                     + NUM_W'(e[COLOR_W-1-k*CHAN_W -: CHAN_W]) * NUM_W'(rem);
                q[k] = CHAN_W'(num / NUM_W'(total));
            end
        end
        px.red   = q[0];
        px.green = q[1];
        px.blue  = q[2];
        px.word  = {q[1], q[0], q[2], 8'h00};
        return px;
    endfunction

    task automatic check_field(input string field, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            errors++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic queue_step(input logic [STEP_W-1:0] now, input logic [STEP_W-1:0] total);
        pending_steps.push_back('{now: now, total: total});
    endtask

    // Wait for every request to return, then let the pipeline settle;
    // sample between edges so the driver's updates have landed
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_steps.size() != 0 || step_if.valid || predicted_pixels.size() != 0);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Random stop set, extremes mixed in; stray indexes now and then
    task automatic program_random();
        int                    sel;
        logic [CNT_W-1:0]      cnt;
        logic [CFG_DATA_W-1:0] color;
        sel = $urandom_range(0, 9);
        if (sel == 0)      cnt = 0;
        else if (sel == 1) cnt = 1;
        else if (sel == 9) cnt = CNT_W'($urandom_range(STOPS + 1, 7));
        else               cnt = CNT_W'($urandom_range(2, STOPS));
        write_reg(REG_STOP_COUNT, {CFG_DATA_W'($urandom) & ~CFG_DATA_W'(7)} | cnt);
        for (int k = 0; k < STOPS; k++) begin
            case ($urandom_range(0, 5))
                0:       color = '0;
                1:       color = '1;
                default: color = CFG_DATA_W'($urandom);
            endcase
            write_reg(REG_STOP_COLOR_0 + CFG_IDX_W'(k), color);
        end
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(STOPS + 1, 255)), CFG_DATA_W'($urandom));
    endtask

    // Mostly in-range steps over short and long transitions
    task automatic queue_random_steps(input int count);
        int                sel;
        logic [STEP_W-1:0] total;
        logic [STEP_W-1:0] now;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)      total = 0;
            else if (sel <= 4) total = STEP_W'($urandom_range(1, 8));
            else if (sel <= 7) total = STEP_W'($urandom_range(9, 64));
            else               total = STEP_W'($urandom_range(65, 255));
            if ($urandom_range(0, 4) == 0) now = STEP_W'($urandom_range(0, 255));
            else                           now = STEP_W'($urandom_range(0, total));
            queue_step(now, total);
        end
    endtask

    // Apply accepted register writes to the mirror
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            if (cfg_if.index == REG_STOP_COUNT)
                stop_cnt <= cfg_if.data[CNT_W-1:0];
            else if (cfg_if.index >= REG_STOP_COLOR_0 &&
                     cfg_if.index < REG_STOP_COLOR_0 + STOPS)
                stop_tbl[cfg_if.index - REG_STOP_COLOR_0] <= cfg_if.data;
        end
    end

    // Step driver: predict on acceptance, hold until accepted, idle in bursts
    always @(posedge i_clk) begin
        t_step_req req;
        if (!i_rst_n) begin
            step_if.valid <= 1'b0;
            step_gap      <= 0;
        end else begin
            if (step_if.valid && step_if.ready)
                predicted_pixels.push_back(blend_pixel(step_if.step_now, step_if.step_total));
            if (step_if.valid && !step_if.ready) begin
                // hold the request
            end else if (step_gap != 0) begin
                step_gap      <= step_gap - 1;
                step_if.valid <= 1'b0;
            end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
                step_gap      <= $urandom_range(0, 6);
                step_if.valid <= 1'b0;
            end else if (pending_steps.size() != 0) begin
                req                = pending_steps.pop_front();
                step_if.valid      <= 1'b1;
                step_if.step_now   <= req.now;
                step_if.step_total <= req.total;
            end else begin
                step_if.valid <= 1'b0;
            end
        end
    end

    // Pixel monitor: compare against the oldest prediction, stall in bursts
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            pix_if.ready <= 1'b0;
            pix_hold     <= 0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                if (predicted_pixels.size() == 0) begin
                    $error("unexpected pixel: red %0h green %0h blue %0h word %0h",
                           pix_if.red, pix_if.green, pix_if.blue, pix_if.pixel_word);
                    errors++;
                end else begin
                    want = predicted_pixels.pop_front();
                    check_field("red", want.red, pix_if.red);
                    check_field("green", want.green, pix_if.green);
                    check_field("blue", want.blue, pix_if.blue);
                    check_field("pixel_word", want.word, pix_if.pixel_word);
                end
            end
            if (pix_hold != 0) begin
                pix_hold     <= pix_hold - 1;
                pix_if.ready <= 1'b0;
            end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
                pix_hold     <= $urandom_range(0, 6);
                pix_if.ready <= 1'b0;
            end else begin
                pix_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: drop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (step_if.valid && step_if.ready) || (pix_if.valid && pix_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("multi_stop_color_gradient_top regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        step_if.valid      = 1'b0;
        step_if.step_now   = '0;
        step_if.step_total = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        pix_if.ready       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no stops after reset: output off
        queue_step(8'd0, 8'd0);
        queue_step(8'd255, 8'd255);
        queue_step(8'd17, 8'd3);
        wait_idle();

        // one stop: first stop whatever the step
        write_reg(REG_STOP_COUNT, 24'd1);
        write_reg(REG_STOP_COLOR_0, 24'hFFFFFF);
        write_reg(REG_STOP_COLOR_0 + 1, 24'h123456);
        queue_step(8'd5, 8'd0);
        queue_step(8'd200, 8'd100);
        wait_idle();

        // two stops black to white: ends, midpoint, zero total, clamped step
        write_reg(REG_STOP_COUNT, 24'd2);
        write_reg(REG_STOP_COLOR_0, 24'h000000);
        write_reg(REG_STOP_COLOR_0 + 1, 24'hFFFFFF);
        queue_step(8'd0, 8'd255);
        queue_step(8'd255, 8'd255);
        queue_step(8'd128, 8'd255);
        queue_step(8'd10, 8'd0);
        queue_step(8'd9, 8'd4);
        wait_idle();

        // all stops: segment edges, last segment cap, unit total
        write_reg(REG_STOP_COUNT, 24'd4);
        write_reg(REG_STOP_COLOR_0, 24'hFF0000);
        write_reg(REG_STOP_COLOR_0 + 1, 24'h00FF00);
        write_reg(REG_STOP_COLOR_0 + 2, 24'h0000FF);
        write_reg(REG_STOP_COLOR_0 + 3, 24'hA5A5A5);
        queue_step(8'd0, 8'd1);
        queue_step(8'd1, 8'd1);
        queue_step(8'd255, 8'd1);
        queue_step(8'd1, 8'd3);
        queue_step(8'd2, 8'd3);
        queue_step(8'd254, 8'd255);
        queue_step(8'd85, 8'd255);
        queue_step(8'd170, 8'd255);
        queue_step(8'd0, 8'd0);
        wait_idle();

        // stop count past the limit saturates; writes past the last stop drop
        write_reg(REG_STOP_COUNT, 24'd7);
        write_reg(REG_STOP_COLOR_0 + STOPS, 24'hFFFFFF);
        write_reg(8'd255, 24'hFFFFFF);
        queue_step(8'd100, 8'd200);
        queue_step(8'd255, 8'd7);
        wait_idle();

        // random stop sets, the last one at full rate
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9) quiet_run = 1'b1;
            program_random();
            queue_random_steps(50);
            wait_idle();
        end

        if (errors == 0)
            $display("multi_stop_color_gradient_top regression: pass");
        else
            $display("multi_stop_color_gradient_top regression: fail");
        $finish;
    end

endmodule
